// ----- hdl/otc_pkg.sv -----
// shared types, widths and constants of the oscillator trim calibrator
package otc_pkg;

    // fixed point format of the slope
    localparam int SLOPE_FRAC_BITS = 16;

    // field widths
    localparam int DAC_W = 16;
    localparam int ERR_W = 32;
    localparam int CMD_W = 2;
    localparam int PHASE_W = 3;
    localparam int WIN_W = 7;

    // slope magnitude and product widths
    localparam int SLOPE_MAG_W = DAC_W + SLOPE_FRAC_BITS;
    localparam int DEN_W = ERR_W + 1;
    localparam int PROD_W = ERR_W + SLOPE_MAG_W;

    // product saturation: above 2^62 the scaled magnitude is held at 2^40
    localparam int SAT_EXP = 62;
    localparam int SAT_VAL_EXP = 40;
    localparam int CMP_W = (PROD_W > SAT_EXP + 1) ? PROD_W : SAT_EXP + 1;
    localparam logic [CMP_W-1:0] SAT_LIMIT = CMP_W'(1) << SAT_EXP;
    localparam logic [CMP_W:0] ROUND_HALF = (CMP_W + 1)'(1) << (SLOPE_FRAC_BITS - 1);

    // width of the rounded product magnitude
    localparam int MAG_W = ((SAT_EXP + 1 - SLOPE_FRAC_BITS) > (SAT_VAL_EXP + 1)) ?
                           (SAT_EXP + 1 - SLOPE_FRAC_BITS) : (SAT_VAL_EXP + 1);
    localparam logic [MAG_W-1:0] MAG_SAT = MAG_W'(1) << SAT_VAL_EXP;

    // divider dividend width, shared by slope and window division
    localparam int SLOPE_DVD_W = ((SLOPE_MAG_W > ERR_W) ? SLOPE_MAG_W : ERR_W) + 1;
    localparam int DVD_W = (SLOPE_DVD_W > MAG_W) ? SLOPE_DVD_W : MAG_W;
    localparam int DIV_CNT_W = $clog2(DVD_W);
    localparam int MUL_CNT_W = $clog2(ERR_W);

    // measurement windows in seconds
    localparam logic [WIN_W-1:0] WIN_1 = WIN_W'(1);
    localparam logic [WIN_W-1:0] WIN_10 = WIN_W'(10);
    localparam logic [WIN_W-1:0] WIN_100 = WIN_W'(100);

    // register reset values
    localparam logic [DAC_W-1:0] DAC_MAX_RESET = 16'hFFFF;
    localparam logic [DAC_W-1:0] DEFAULT_DAC_RESET = 16'h77FA;

    // stream widths, whole bytes
    localparam int IN_FIELDS_W = 3 * ERR_W + 3;
    localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DAC_W + 3 + PHASE_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DAC_MAX     = 1'b0,
        REG_DEFAULT_DAC = 1'b1
    } otc_reg_t;

    // item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_ENABLE  = 2'd0,
        CMD_DISABLE = 2'd1,
        CMD_MEASURE = 2'd2,
        CMD_NONE    = 2'd3
    } otc_cmd_code_t;

    // tuning phases
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE  = 3'd0,
        PH_CMIN  = 3'd1,
        PH_CMAX  = 3'd2,
        PH_CDONE = 3'd3,
        PH_FINE  = 3'd4
    } otc_phase_t;

    // source of a new dac code
    typedef enum logic [2:0] {
        DAC_ZERO      = 3'd0,
        DAC_MAX       = 3'd1,
        DAC_DEFAULT   = 3'd2,
        DAC_INTERCEPT = 3'd3,
        DAC_FINE      = 3'd4
    } otc_dac_sel_t;

    typedef enum logic {
        MUL_ERR_MIN  = 1'b0,
        MUL_FINE_ERR = 1'b1
    } otc_mul_sel_t;

    typedef enum logic {
        DIV_SLOPE  = 1'b0,
        DIV_WINDOW = 1'b1
    } otc_div_sel_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SLOPE_DIV,
        S_COARSE_START,
        S_COARSE_MUL,
        S_COARSE_SET,
        S_FINE_MUL,
        S_FINE_WIN,
        S_FINE_DIV,
        S_EMIT
    } otc_state_t;

    // one input item
    typedef struct packed {
        otc_cmd_code_t       cmd;
        logic [ERR_W-1:0]    err_1s;
        logic [ERR_W-1:0]    err_10s;
        logic [ERR_W-1:0]    err_100s;
        logic                flag_1s;
        logic                flag_10s;
        logic                flag_100s;
    } otc_item_t;

    // one result item, dac code in the lowest bits
    typedef struct packed {
        otc_phase_t          phase;
        logic                coarse_done;
        logic                restart_counters;
        logic                dac_write;
        logic [DAC_W-1:0]    dac_code;
    } otc_res_t;

    // controller to datapath
    typedef struct packed {
        logic                capture;
        logic                phase_load;
        otc_phase_t          phase_val;
        logic                dac_load;
        otc_dac_sel_t        dac_sel;
        logic                err_min_load;
        logic                slope_load;
        logic                mul_start;
        otc_mul_sel_t        mul_sel;
        logic                div_start;
        otc_div_sel_t        div_sel;
        logic                res_clear;
        logic                set_wr;
        logic                set_rst;
        logic                set_done;
        logic                emit;
    } otc_ctl_t;

    // datapath to controller
    typedef struct packed {
        otc_cmd_code_t       cmd;
        otc_phase_t          phase;
        logic                diff_zero;
        logic                any_flag;
        logic                mul_done;
        logic                div_done;
    } otc_stat_t;

endpackage

// ----- hdl/oscillator_trim_calibrator.sv -----
// top level: stream ports, configuration port and output register
// flow: enable, disable and coarse steps go from the decode state to the emit state, which waits
//   for a free output register; the coarse-done step with a slope first runs the DVD_W-step
//   restoring divider (47 steps at 16 fraction bits) and then the 32-step shift-add multiplier,
//   and a fine correction runs the same multiplier first and then the divider
// throughput: one item at a time; the next beat is taken once the result is in the output register
// reset: rst_n clears the sequencer, the tuning state (dac code to the default) and the registers
module oscillator_trim_calibrator (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // err_1s[31:0], err_10s[63:32], err_100s[95:64], flag_1s[96], flag_10s[97],
    // flag_100s[98], zero fill
    input  logic [otc_pkg::IN_TDATA_W-1:0]     s_tdata,
    // cmd[1:0]
    input  logic [otc_pkg::CMD_W-1:0]          s_tuser,
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // dac_code[15:0], dac_write[16], restart_counters[17], coarse_done[18],
    // phase[21:19], zero fill
    output logic [otc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [otc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [otc_pkg::DAC_W-1:0]          cfg_data
);
    import otc_pkg::*;

    otc_item_t  item;
    otc_ctl_t   ctl;
    otc_stat_t  stat;
    otc_res_t   res;
    otc_res_t   out_res_reg;
    logic       out_valid_reg;
    logic       idle;
    logic       in_beat;
    logic       out_free;

    // unpack the input beat
    always_comb
    begin
        item.cmd       = otc_cmd_code_t'(s_tuser);
        item.err_1s    = s_tdata[ERR_W-1:0];
        item.err_10s   = s_tdata[2*ERR_W-1:ERR_W];
        item.err_100s  = s_tdata[3*ERR_W-1:2*ERR_W];
        item.flag_1s   = s_tdata[3*ERR_W];
        item.flag_10s  = s_tdata[3*ERR_W+1];
        item.flag_100s = s_tdata[3*ERR_W+2];
    end

    assign s_tready  = idle;
    assign in_beat   = s_tvalid && idle;
    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    otc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (in_beat),
        .out_free (out_free),
        .stat     (stat),
        .idle     (idle),
        .ctl      (ctl)
    );

    otc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_reg   (otc_reg_t'(cfg_index)),
        .cfg_value (cfg_data),
        .item      (item),
        .ctl       (ctl),
        .stat      (stat),
        .res       (res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_res_reg);

    // an accepted beat moves the sequencer out of idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("sequencer stayed idle after an input beat");

    // a counter restart always comes with a dac write
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res_reg.restart_counters) |-> out_res_reg.dac_write)
        else $error("counter restart without dac write");

    // finishing coarse calibration writes the dac and enters fine tuning
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res_reg.coarse_done) |->
        (out_res_reg.dac_write && out_res_reg.phase == PH_FINE))
        else $error("coarse done without write or fine phase");

    // a new result appears only when the sequencer hands one over
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(ctl.emit))
        else $error("output beat without a finished item");

endmodule

// ----- hdl/otc_mul.sv -----
// shift-add multiplier, one multiplier bit per cycle
module otc_mul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [otc_pkg::ERR_W-1:0]       a,
    input  logic [otc_pkg::SLOPE_MAG_W-1:0] b,
    output logic                           done,
    output logic [otc_pkg::PROD_W-1:0]      product
);
    import otc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [ERR_W-1:0]     a_reg;
    logic [PROD_W-1:0]    b_reg;
    logic [PROD_W-1:0]    acc_reg;

    // control: counts the multiplier bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + MUL_CNT_W'(1);
                if (cnt_reg == MUL_CNT_W'(ERR_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // partial product accumulation
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= PROD_W'(b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (a_reg[0])
            begin
                acc_reg <= acc_reg + b_reg;
            end
            a_reg <= a_reg >> 1;
            b_reg <= b_reg << 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- hdl/otc_div.sv -----
// restoring divider, one quotient bit per cycle
module otc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [otc_pkg::DVD_W-1:0]   dividend,
    input  logic [otc_pkg::DEN_W-1:0]   divisor,
    output logic                       done,
    output logic [otc_pkg::DVD_W-1:0]   quotient
);
    import otc_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DVD_W-1:0]     quo_reg;
    logic [DEN_W:0]       shifted;
    logic                 ge;

    // trial subtraction
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DVD_W-1]};
        ge      = (shifted >= {1'b0, den_reg});
    end

    // control: counts the quotient bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/otc_datapath.sv -----
// calibration datapath: registers, slope and correction arithmetic
module otc_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  otc_pkg::otc_reg_t            cfg_reg,
    input  logic [otc_pkg::DAC_W-1:0]     cfg_value,
    input  otc_pkg::otc_item_t           item,
    input  otc_pkg::otc_ctl_t            ctl,
    output otc_pkg::otc_stat_t           stat,
    output otc_pkg::otc_res_t            res
);
    import otc_pkg::*;

    // configuration and architectural state
    logic [DAC_W-1:0]       dac_max_reg;
    logic [DAC_W-1:0]       default_dac_reg;
    otc_phase_t             phase_reg;
    logic [DAC_W-1:0]       dac_reg;
    logic [ERR_W-1:0]       err_min_reg;
    logic                   slope_neg_reg;
    logic [SLOPE_MAG_W-1:0] slope_mag_reg;

    // working registers
    otc_item_t              item_reg;
    logic                   prod_neg_reg;
    logic [WIN_W-1:0]       win_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic                   res_wr_reg;
    logic                   res_rst_reg;
    logic                   res_done_reg;

    logic [DEN_W-1:0]       diff;
    logic                   diff_neg;
    logic [DEN_W-1:0]       den;
    logic [ERR_W-1:0]       fine_err;
    logic [WIN_W-1:0]       fine_win;
    logic                   any_flag;
    logic [ERR_W-1:0]       mul_err;
    logic [ERR_W-1:0]       mul_a;
    logic                   mul_done;
    logic [PROD_W-1:0]      product;
    logic [CMP_W-1:0]       prod_ext;
    logic [CMP_W:0]         prod_rnd;
    logic [MAG_W-1:0]       mag_next;
    logic [DVD_W-1:0]       div_dividend;
    logic [DEN_W-1:0]       div_divisor;
    logic                   div_done;
    logic [DVD_W-1:0]       div_quo;
    logic [DAC_W-1:0]       intercept;
    logic [DVD_W+1:0]       fine_val;
    logic [DAC_W-1:0]       fine_dac;
    logic [DAC_W-1:0]       dac_next;

    // line difference e1 - e0
    always_comb
    begin
        diff     = {item_reg.err_1s[ERR_W-1], item_reg.err_1s}
                 - {err_min_reg[ERR_W-1], err_min_reg};
        diff_neg = diff[DEN_W-1];
        den      = diff_neg ? (DEN_W'(0) - diff) : diff;
    end

    // first flagged window wins
    always_comb
    begin
        fine_err = item_reg.err_100s;
        fine_win = WIN_100;
        if (item_reg.flag_10s)
        begin
            fine_err = item_reg.err_10s;
            fine_win = WIN_10;
        end
        if (item_reg.flag_1s)
        begin
            fine_err = item_reg.err_1s;
            fine_win = WIN_1;
        end
        any_flag = item_reg.flag_1s | item_reg.flag_10s | item_reg.flag_100s;
    end

    // multiplier operand magnitude
    always_comb
    begin
        mul_err = (ctl.mul_sel == MUL_ERR_MIN) ? err_min_reg : fine_err;
        mul_a   = mul_err[ERR_W-1] ? (ERR_W'(0) - mul_err) : mul_err;
    end

    otc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctl.mul_start),
        .a       (mul_a),
        .b       (slope_mag_reg),
        .done    (mul_done),
        .product (product)
    );

    // round to nearest and saturate the product magnitude
    always_comb
    begin
        prod_ext = CMP_W'(product);
        prod_rnd = ({1'b0, prod_ext} + ROUND_HALF) >> SLOPE_FRAC_BITS;
        mag_next = (prod_ext > SAT_LIMIT) ? MAG_SAT : prod_rnd[MAG_W-1:0];
    end

    // divider operands
    always_comb
    begin
        if (ctl.div_sel == DIV_SLOPE)
        begin
            div_dividend = DVD_W'({dac_max_reg, {SLOPE_FRAC_BITS{1'b0}}})
                         + DVD_W'(den >> 1);
            div_divisor  = den;
        end
        else
        begin
            div_dividend = DVD_W'(mag_reg);
            div_divisor  = DEN_W'(win_reg);
        end
    end

    otc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // intercept: -(signed product), clamped to the dac range
    always_comb
    begin
        if (!prod_neg_reg)
        begin
            intercept = '0;
        end
        else if (mag_reg > MAG_W'(dac_max_reg))
        begin
            intercept = dac_max_reg;
        end
        else
        begin
            intercept = mag_reg[DAC_W-1:0];
        end
    end

    // fine correction: dac minus truncated window quotient, clamped
    always_comb
    begin
        fine_val = prod_neg_reg ? ((DVD_W + 2)'(dac_reg) + (DVD_W + 2)'(div_quo))
                                : ((DVD_W + 2)'(dac_reg) - (DVD_W + 2)'(div_quo));
        if (fine_val[DVD_W+1])
        begin
            fine_dac = '0;
        end
        else if (fine_val > (DVD_W + 2)'(dac_max_reg))
        begin
            fine_dac = dac_max_reg;
        end
        else
        begin
            fine_dac = fine_val[DAC_W-1:0];
        end
    end

    // new dac code
    always_comb
    begin
        unique case (ctl.dac_sel)
            DAC_ZERO:      dac_next = '0;
            DAC_MAX:       dac_next = dac_max_reg;
            DAC_DEFAULT:   dac_next = default_dac_reg;
            DAC_INTERCEPT: dac_next = intercept;
            DAC_FINE:      dac_next = fine_dac;
            default:       dac_next = dac_reg;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dac_max_reg     <= DAC_MAX_RESET;
            default_dac_reg <= DEFAULT_DAC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg)
                REG_DAC_MAX:     dac_max_reg     <= cfg_value;
                REG_DEFAULT_DAC: default_dac_reg <= cfg_value;
                default:         ;
            endcase
        end
    end

    // tuning state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            dac_reg       <= DEFAULT_DAC_RESET;
            err_min_reg   <= '0;
            slope_neg_reg <= 1'b0;
            slope_mag_reg <= '0;
            res_wr_reg    <= 1'b0;
            res_rst_reg   <= 1'b0;
            res_done_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.phase_load)
            begin
                phase_reg <= ctl.phase_val;
            end
            if (ctl.dac_load)
            begin
                dac_reg <= dac_next;
            end
            if (ctl.err_min_load)
            begin
                err_min_reg <= item_reg.err_1s;
            end
            if (ctl.slope_load)
            begin
                slope_mag_reg <= div_quo[SLOPE_MAG_W-1:0];
                slope_neg_reg <= diff_neg && (div_quo != '0);
            end
            // result pulses, cleared per item
            if (ctl.res_clear)
            begin
                res_wr_reg   <= 1'b0;
                res_rst_reg  <= 1'b0;
                res_done_reg <= 1'b0;
            end
            if (ctl.set_wr)
            begin
                res_wr_reg <= 1'b1;
            end
            if (ctl.set_rst)
            begin
                res_rst_reg <= 1'b1;
            end
            if (ctl.set_done)
            begin
                res_done_reg <= 1'b1;
            end
        end
    end

    // item and operand capture
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            item_reg <= item;
        end
        if (ctl.mul_start)
        begin
            prod_neg_reg <= mul_err[ERR_W-1] ^ slope_neg_reg;
            win_reg      <= fine_win;
        end
        if (mul_done)
        begin
            mag_reg <= mag_next;
        end
    end

    // status and result
    always_comb
    begin
        stat.cmd       = item_reg.cmd;
        stat.phase     = phase_reg;
        stat.diff_zero = (diff == '0);
        stat.any_flag  = any_flag;
        stat.mul_done  = mul_done;
        stat.div_done  = div_done;

        res.phase            = phase_reg;
        res.coarse_done      = res_done_reg;
        res.restart_counters = res_rst_reg;
        res.dac_write        = res_wr_reg;
        res.dac_code         = dac_reg;
    end

endmodule

// ----- hdl/otc_ctrl.sv -----
// calibration sequencer
module otc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_beat,
    input  logic                out_free,
    input  otc_pkg::otc_stat_t  stat,
    output logic                idle,
    output otc_pkg::otc_ctl_t   ctl
);
    import otc_pkg::*;

    otc_state_t state_reg;
    otc_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.capture = in_beat;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                ctl.res_clear = 1'b1;
                state_next    = S_EMIT;
                unique case (stat.cmd)
                    CMD_DISABLE:
                    begin
                        ctl.phase_load = 1'b1;
                        ctl.phase_val  = PH_IDLE;
                    end
                    CMD_ENABLE:
                    begin
                        // restart coarse calibration at dac zero
                        ctl.dac_load   = 1'b1;
                        ctl.dac_sel    = DAC_ZERO;
                        ctl.set_wr     = 1'b1;
                        ctl.set_rst    = 1'b1;
                        ctl.phase_load = 1'b1;
                        ctl.phase_val  = PH_CMAX;
                    end
                    CMD_MEASURE:
                    begin
                        unique case (stat.phase)
                            PH_CMIN:
                            begin
                                ctl.dac_load   = 1'b1;
                                ctl.dac_sel    = DAC_ZERO;
                                ctl.set_wr     = 1'b1;
                                ctl.set_rst    = 1'b1;
                                ctl.phase_load = 1'b1;
                                ctl.phase_val  = PH_CMAX;
                            end
                            PH_CMAX:
                            begin
                                // first point taken, go to the top of the range
                                ctl.err_min_load = 1'b1;
                                ctl.dac_load     = 1'b1;
                                ctl.dac_sel      = DAC_MAX;
                                ctl.set_wr       = 1'b1;
                                ctl.set_rst      = 1'b1;
                                ctl.phase_load   = 1'b1;
                                ctl.phase_val    = PH_CDONE;
                            end
                            PH_CDONE:
                            begin
                                if (stat.diff_zero)
                                begin
                                    // flat line: fall back to the default code
                                    ctl.dac_load   = 1'b1;
                                    ctl.dac_sel    = DAC_DEFAULT;
                                    ctl.set_wr     = 1'b1;
                                    ctl.set_done   = 1'b1;
                                    ctl.phase_load = 1'b1;
                                    ctl.phase_val  = PH_FINE;
                                end
                                else
                                begin
                                    ctl.div_start = 1'b1;
                                    ctl.div_sel   = DIV_SLOPE;
                                    state_next    = S_SLOPE_DIV;
                                end
                            end
                            PH_FINE:
                            begin
                                if (stat.any_flag)
                                begin
                                    ctl.mul_start = 1'b1;
                                    ctl.mul_sel   = MUL_FINE_ERR;
                                    state_next    = S_FINE_MUL;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_SLOPE_DIV:
            begin
                if (stat.div_done)
                begin
                    ctl.slope_load = 1'b1;
                    state_next     = S_COARSE_START;
                end
            end

            S_COARSE_START:
            begin
                ctl.mul_start = 1'b1;
                ctl.mul_sel   = MUL_ERR_MIN;
                state_next    = S_COARSE_MUL;
            end

            S_COARSE_MUL:
            begin
                if (stat.mul_done)
                begin
                    state_next = S_COARSE_SET;
                end
            end

            S_COARSE_SET:
            begin
                ctl.dac_load   = 1'b1;
                ctl.dac_sel    = DAC_INTERCEPT;
                ctl.set_wr     = 1'b1;
                ctl.set_done   = 1'b1;
                ctl.phase_load = 1'b1;
                ctl.phase_val  = PH_FINE;
                state_next     = S_EMIT;
            end

            S_FINE_MUL:
            begin
                if (stat.mul_done)
                begin
                    state_next = S_FINE_WIN;
                end
            end

            S_FINE_WIN:
            begin
                ctl.div_start = 1'b1;
                ctl.div_sel   = DIV_WINDOW;
                state_next    = S_FINE_DIV;
            end

            S_FINE_DIV:
            begin
                ctl.div_sel = DIV_WINDOW;
                if (stat.div_done)
                begin
                    ctl.dac_load = 1'b1;
                    ctl.dac_sel  = DAC_FINE;
                    ctl.set_wr   = 1'b1;
                    state_next   = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == S_IDLE);

endmodule

// ----- tb/oscillator_trim_calibrator_tb.sv -----
// self-checking testbench for the oscillator trim calibrator stream block
`timescale 1ns / 100ps

module oscillator_trim_calibrator_tb;
    import otc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 200;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]        s_tuser = CMD_NONE;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = REG_DAC_MAX;
    logic [DAC_W-1:0]        cfg_data = '0;

    // predicted block state and registers
    logic [DAC_W-1:0]        cap_code = DAC_MAX_RESET;
    logic [DAC_W-1:0]        fallback_code = DEFAULT_DAC_RESET;
    logic [DAC_W-1:0]        trim_code = DEFAULT_DAC_RESET;
    otc_phase_t              trim_phase = PH_IDLE;
    longint                  e0_hold = 0;
    longint                  slope_fx = 0;

    otc_res_t                expected_trims[$];
    int                      items_sent = 0;
    int                      results_seen = 0;
    int                      mismatches = 0;
    int                      cycle_count = 0;
    logic                    steady = 1'b0;

    oscillator_trim_calibrator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stall, off during the steady stretch
    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= 24);
    end

    // round(err * slope / 2^frac), ties away from zero, magnitude held at 2^40
    function automatic longint slope_times_err(input longint err, input longint slope);
        logic        neg;
        logic [63:0] a;
        logic [63:0] s;
        logic [63:0] m;
        logic [63:0] p;
        neg = (err < 0) != (slope < 0);
        a = (err < 0) ? -err : err;
        s = (slope < 0) ? -slope : slope;
        if (s != 0 && a > ((64'd1 << SAT_EXP) / s))
            m = 64'd1 << SAT_VAL_EXP;
        else
        begin
            p = a * s;
            m = (p + (64'd1 << (SLOPE_FRAC_BITS - 1))) >> SLOPE_FRAC_BITS;
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [DAC_W-1:0] clamp_code(input longint v);
        if (v < 0)
            return '0;
        if (v > longint'({48'd0, cap_code}))
            return cap_code;
        return v[DAC_W-1:0];
    endfunction

    // advance the predicted state by one accepted beat
    function automatic otc_res_t trim_step(input otc_item_t it);
        otc_res_t    r;
        longint      e_now;
        longint      diff;
        longint      err_sel;
        longint      win;
        longint      adj;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] q;
        r = '0;
        e_now = longint'($signed(it.err_1s));
        if (it.cmd == CMD_DISABLE)
            trim_phase = PH_IDLE;
        else if (it.cmd == CMD_ENABLE || (it.cmd == CMD_MEASURE && trim_phase == PH_CMIN))
        begin
            trim_code = '0;
            r.dac_write = 1'b1;
            r.restart_counters = 1'b1;
            trim_phase = PH_CMAX;
        end
        else if (it.cmd == CMD_MEASURE)
        begin
            case (trim_phase)
                PH_CMAX:
                begin
                    e0_hold = e_now;
                    trim_code = cap_code;
                    r.dac_write = 1'b1;
                    r.restart_counters = 1'b1;
                    trim_phase = PH_CDONE;
                end
                PH_CDONE:
                begin
                    diff = e_now - e0_hold;
                    if (diff != 0)
                    begin
                        den = (diff < 0) ? -diff : diff;
                        num = {48'd0, cap_code} << SLOPE_FRAC_BITS;
                        q = (num + den / 2) / den;
                        slope_fx = (diff < 0) ? -longint'(q) : longint'(q);
                        trim_code = clamp_code(-slope_times_err(e0_hold, slope_fx));
                    end
                    else
                        trim_code = fallback_code;
                    r.dac_write = 1'b1;
                    r.coarse_done = 1'b1;
                    trim_phase = PH_FINE;
                end
                PH_FINE:
                begin
                    // first flagged window wins
                    err_sel = 0;
                    win = 0;
                    if (it.flag_1s)
                    begin
                        err_sel = e_now;
                        win = 1;
                    end
                    else if (it.flag_10s)
                    begin
                        err_sel = longint'($signed(it.err_10s));
                        win = 10;
                    end
                    else if (it.flag_100s)
                    begin
                        err_sel = longint'($signed(it.err_100s));
                        win = 100;
                    end
                    if (win != 0)
                    begin
                        adj = slope_times_err(err_sel, slope_fx) / win;
                        trim_code = clamp_code(longint'({48'd0, trim_code}) - adj);
                        r.dac_write = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.dac_code = trim_code;
        r.phase = trim_phase;
        return r;
    endfunction

    // result check, then prediction of accepted input and register beats
    always @(posedge clk)
    begin : bus_monitor
        otc_res_t  got;
        otc_res_t  want;
        otc_item_t beat;
        if (m_tvalid && m_tready)
        begin
            got = otc_res_t'(m_tdata[OUT_FIELDS_W-1:0]);
            results_seen++;
            if (expected_trims.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %h", m_tdata);
            end
            else
            begin
                want = expected_trims.pop_front();
                if (got.dac_code !== want.dac_code || got.dac_write !== want.dac_write ||
                    got.restart_counters !== want.restart_counters ||
                    got.coarse_done !== want.coarse_done || got.phase !== want.phase)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected code %h wr %b rst %b done %b phase %0d,",
                                  " got code %h wr %b rst %b done %b phase %0d"},
                                 results_seen, want.dac_code, want.dac_write,
                                 want.restart_counters, want.coarse_done, want.phase,
                                 got.dac_code, got.dac_write, got.restart_counters,
                                 got.coarse_done, got.phase);
                end
            end
        end
        if (s_tvalid && s_tready)
        begin
            beat.cmd = otc_cmd_code_t'(s_tuser);
            beat.err_1s = s_tdata[ERR_W-1:0];
            beat.err_10s = s_tdata[2*ERR_W-1:ERR_W];
            beat.err_100s = s_tdata[3*ERR_W-1:2*ERR_W];
            beat.flag_1s = s_tdata[3*ERR_W];
            beat.flag_10s = s_tdata[3*ERR_W+1];
            beat.flag_100s = s_tdata[3*ERR_W+2];
            expected_trims.push_back(trim_step(beat));
        end
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DAC_MAX:     cap_code = cfg_data;
                REG_DEFAULT_DAC: fallback_code = cfg_data;
                default: ;
            endcase
        end
    end

    function automatic otc_item_t make_item(input otc_cmd_code_t c, input logic [31:0] e1s,
                                            input logic [31:0] e10s, input logic [31:0] e100s,
                                            input logic f1, input logic f10, input logic f100);
        otc_item_t it;
        it.cmd = c;
        it.err_1s = e1s;
        it.err_10s = e10s;
        it.err_100s = e100s;
        it.flag_1s = f1;
        it.flag_10s = f10;
        it.flag_100s = f100;
        return it;
    endfunction

    // error spread over several magnitude classes
    function automatic logic [31:0] rand_err();
        case ($urandom_range(3))
            0:       return 32'(int'($urandom_range(2000)) - 1000);
            1:       return 32'(int'($urandom_range(131072)) - 65536);
            2:       return 32'(int'($urandom_range(33554432)) - 16777216);
            default: return $urandom();
        endcase
    endfunction

    // one input beat, with random gaps ahead of it
    task automatic send_item(input otc_item_t it);
        while (!steady && $urandom_range(99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.cmd;
        s_tdata <= IN_TDATA_W'({it.flag_100s, it.flag_10s, it.flag_1s,
                                it.err_100s, it.err_10s, it.err_1s});
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic measure(input logic [31:0] e1s, input logic [31:0] e10s,
                           input logic [31:0] e100s, input logic f1, input logic f10,
                           input logic f100);
        send_item(make_item(CMD_MEASURE, e1s, e10s, e100s, f1, f10, f100));
    endtask

    task automatic command(input otc_cmd_code_t c);
        send_item(make_item(c, rand_err(), rand_err(), rand_err(), 1'b1, 1'b1, 1'b1));
    endtask

    // hold the sender until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_seen != items_sent);
    endtask

    // both registers, written back to back while the block is idle
    task automatic set_regs(input logic [DAC_W-1:0] cap, input logic [DAC_W-1:0] fallback);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= REG_DAC_MAX;
        cfg_data <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= REG_DEFAULT_DAC;
        cfg_data <= fallback;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // commands that leave an idle block alone
    task automatic test_idle_commands();
        measure(32'd1234, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0);
        command(CMD_NONE);
        command(CMD_DISABLE);
    endtask

    // repeated enable, then both coarse points
    task automatic test_coarse_sequence();
        command(CMD_ENABLE);
        command(CMD_ENABLE);
        measure(-32'sd1000, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        measure(32'sd1000, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
    endtask

    // window priority, no flag, field extremes, disable keeping the code
    task automatic test_fine_windows();
        measure(32'sd5, 32'sd77, 32'sd999, 1'b1, 1'b0, 1'b0);
        measure(32'sd40, -32'sd300, 32'sd999, 1'b0, 1'b1, 1'b0);
        measure(32'sd40, 32'sd88, 32'sd12345, 1'b0, 1'b0, 1'b1);
        measure(-32'sd7, 32'sd5000, -32'sd5000, 1'b1, 1'b1, 1'b1);
        measure(32'sd9999, 32'sd9999, 32'sd9999, 1'b0, 1'b0, 1'b0);
        command(CMD_NONE);
        measure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
        measure(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 1'b0);
        command(CMD_DISABLE);
    endtask

    // equal coarse errors: default code, slope kept
    task automatic test_degenerate_line();
        command(CMD_ENABLE);
        measure(32'h8000_0000, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        measure(32'h8000_0000, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        measure(32'd0, 32'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1);
    endtask

    // steepest and flattest slopes, product saturation
    task automatic test_saturation();
        command(CMD_ENABLE);
        measure(32'sd5, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        measure(32'sd6, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        measure(32'h8000_0000, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0);
        command(CMD_ENABLE);
        measure(32'h7FFF_FFFF, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        measure(32'h8000_0000, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        measure(32'd0, 32'h8000_0000, 32'd0, 1'b0, 1'b1, 1'b0);
    endtask

    // register extremes, code left above a lowered cap
    task automatic test_register_extremes();
        set_regs(16'h0000, 16'h0000);
        command(CMD_ENABLE);
        measure(32'sd100, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        measure(32'sd200, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        measure(32'sd50, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0);
        set_regs(16'hFFFF, 16'hFFFF);
        command(CMD_ENABLE);
        measure(32'sd7, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        measure(32'sd7, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        set_regs(16'd100, 16'h0001);
        measure(32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        measure(32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0);
        set_regs(16'd1, 16'h0000);
        command(CMD_ENABLE);
        measure(32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        measure(32'sd1, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
        measure(-32'sd1, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0);
        set_regs(DAC_MAX_RESET, DEFAULT_DAC_RESET);
    endtask

    // mostly full calibration runs with random content, some noise
    task automatic test_random_calibration();
        int          target;
        int          n_fine;
        logic [31:0] e0;
        logic [31:0] e1;
        logic [15:0] cap;
        target = items_sent + 1100;
        while (items_sent < target)
        begin
            steady = (items_sent >= target - 700) && (items_sent < target - 450);
            if ($urandom_range(99) < 8)
            begin
                case ($urandom_range(9))
                    0:       cap = 16'h0000;
                    1:       cap = 16'hFFFF;
                    2, 3:    cap = 16'($urandom());
                    default: cap = 16'($urandom_range(65535, 1024));
                endcase
                set_regs(cap, 16'($urandom()));
            end
            else if ($urandom_range(99) < 5)
                drain();
            if ($urandom_range(99) < 80)
            begin
                command(CMD_ENABLE);
                e0 = rand_err();
                e1 = ($urandom_range(9) == 0) ? e0 : e0 + rand_err();
                measure(e0, rand_err(), rand_err(), 1'($urandom()), 1'($urandom()),
                        1'($urandom()));
                // occasionally break the coarse sequence
                if ($urandom_range(99) < 5)
                    command(otc_cmd_code_t'($urandom_range(3)));
                measure(e1, rand_err(), rand_err(), 1'($urandom()), 1'($urandom()),
                        1'($urandom()));
                n_fine = $urandom_range(12, 1);
                repeat (n_fine)
                begin
                    if ($urandom_range(99) < 4)
                        command(otc_cmd_code_t'($urandom_range(3)));
                    else
                        measure(rand_err(), rand_err(), rand_err(),
                                $urandom_range(99) < 35, $urandom_range(99) < 35,
                                $urandom_range(99) < 35);
                end
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    send_item(make_item(otc_cmd_code_t'($urandom_range(3)), $urandom(),
                                        $urandom(), $urandom(), 1'($urandom()),
                                        1'($urandom()), 1'($urandom())));
            end
        end
        steady = 1'b0;
        drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_commands();
        test_coarse_sequence();
        test_fine_windows();
        test_degenerate_line();
        test_saturation();
        test_register_extremes();
        test_random_calibration();
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_trims.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
